// File: rtl/core/qmr_pkg.sv
package qmr_pkg;

	typedef logic [1:0] kind_t;

	// Item kinds; the fourth code is unused and yields an all-zero result.
	localparam kind_t KIND_MUL     = 2'd0;
	localparam kind_t KIND_ROT_FWD = 2'd1;
	localparam kind_t KIND_ROT_REV = 2'd2;

	// Register stages in one quaternion product unit.
	localparam int QMUL_LAT = 4;

	// Hamilton product: component k, term t multiplies p[t] by q[TERM_Q[k][t]].
	localparam logic [1:0] TERM_Q [4][4] = '{
		'{2'd0, 2'd1, 2'd2, 2'd3},
		'{2'd1, 2'd0, 2'd3, 2'd2},
		'{2'd2, 2'd3, 2'd0, 2'd1},
		'{2'd3, 2'd2, 2'd1, 2'd0}
	};

	// Bit t set where term t of component k is subtracted.
	localparam logic [3:0] TERM_NEG [4] = '{4'b1110, 4'b1000, 4'b0010, 4'b0100};

endpackage

// File: rtl/core/qmr_in_if.sv
interface qmr_in_if #(parameter int WIDTH = 32);
	logic                    valid;
	logic                    ready;
	qmr_pkg::kind_t          kind;
	logic signed [WIDTH-1:0] a_w;
	logic signed [WIDTH-1:0] a_x;
	logic signed [WIDTH-1:0] a_y;
	logic signed [WIDTH-1:0] a_z;
	logic signed [WIDTH-1:0] b_w;
	logic signed [WIDTH-1:0] b_x;
	logic signed [WIDTH-1:0] b_y;
	logic signed [WIDTH-1:0] b_z;

	modport source (output valid, kind, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z,
		input ready);
	modport sink (input valid, kind, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z,
		output ready);
endinterface

// File: rtl/core/qmr_out_if.sv
interface qmr_out_if #(parameter int WIDTH = 32);
	logic                    valid;
	logic                    ready;
	logic signed [WIDTH-1:0] r_w;
	logic signed [WIDTH-1:0] r_x;
	logic signed [WIDTH-1:0] r_y;
	logic signed [WIDTH-1:0] r_z;

	modport source (output valid, r_w, r_x, r_y, r_z, input ready);
	modport sink (input valid, r_w, r_x, r_y, r_z, output ready);
endinterface

// File: rtl/core/qmr_qmul.sv
module qmr_qmul #(parameter int WIDTH = 32) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_valid,
	input  logic signed [WIDTH-1:0] p [4],
	input  logic signed [WIDTH-1:0] q [4],
	input  logic                    pconj,
	input  logic                    qconj,
	output logic                    out_valid,
	output logic signed [WIDTH-1:0] r [4]
);
	import qmr_pkg::*;

	// Operands are split at HB; the result keeps FB fraction bits.
	localparam int HB = WIDTH / 2;
	localparam int UB = WIDTH - HB;
	localparam int FB = WIDTH / 2;
	localparam int PW = 2 * WIDTH;
	localparam int AW = PW + 2;
	localparam int TW = AW - FB - WIDTH + 1;
	localparam logic signed [AW-1:0] HALF = {{(AW-FB){1'b0}}, 1'b1, {(FB-1){1'b0}}};
	localparam logic signed [WIDTH-1:0] MAXV = {1'b0, {(WIDTH-1){1'b1}}};
	localparam logic signed [WIDTH-1:0] MINV = {1'b1, {(WIDTH-1){1'b0}}};

	logic signed [2*UB-1:0] hh_s1 [4][4];
	logic signed [WIDTH:0]  hl_s1 [4][4];
	logic signed [WIDTH:0]  lh_s1 [4][4];
	logic [2*HB-1:0]        ll_s1 [4][4];
	logic                   neg_s1 [4][4];
	logic signed [PW-1:0]   prod_s2 [4][4];
	logic                   neg_s2 [4][4];
	logic signed [AW-1:0]   acc_s3 [4];
	logic signed [WIDTH-1:0] r_s4 [4];
	logic v_s1, v_s2, v_s3, v_s4;

	logic signed [AW-1:0]   acc_d [4];
	logic [TW-1:0]          hi_d [4];
	logic signed [WIDTH-1:0] sat_d [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Stage 1: partial products of the upper (signed) and lower (unsigned) halves.
	// A conjugate flips the sign of every term that uses a vector component.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) begin
				for (int t = 0; t < 4; t++) begin
					hh_s1[k][t] <= $signed(p[t][WIDTH-1:HB]) *
						$signed(q[TERM_Q[k][t]][WIDTH-1:HB]);
					hl_s1[k][t] <= $signed(p[t][WIDTH-1:HB]) *
						$signed({1'b0, q[TERM_Q[k][t]][HB-1:0]});
					lh_s1[k][t] <= $signed({1'b0, p[t][HB-1:0]}) *
						$signed(q[TERM_Q[k][t]][WIDTH-1:HB]);
					ll_s1[k][t] <= p[t][HB-1:0] * q[TERM_Q[k][t]][HB-1:0];
					neg_s1[k][t] <= TERM_NEG[k][t] ^ (pconj & (t != 0)) ^
						(qconj & (TERM_Q[k][t] != 2'd0));
				end
			end
		end
	end

	// Stage 2: full products.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) begin
				for (int t = 0; t < 4; t++) begin
					prod_s2[k][t] <= (PW'(hh_s1[k][t]) <<< (2 * HB)) +
						(PW'(hl_s1[k][t]) <<< HB) + (PW'(lh_s1[k][t]) <<< HB) +
						PW'(ll_s1[k][t]);
					neg_s2[k][t] <= neg_s1[k][t];
				end
			end
		end
	end

	// Stage 3: signed sum of the four terms plus half an LSB of the result.
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			acc_d[k] = HALF;
			for (int t = 0; t < 4; t++) begin
				acc_d[k] = neg_s2[k][t] ? acc_d[k] - AW'(prod_s2[k][t])
					: acc_d[k] + AW'(prod_s2[k][t]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			acc_s3 <= acc_d;
		end
	end

	// Stage 4: drop the fraction bits and saturate when the upper bits are not
	// a plain sign extension.
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			hi_d[k] = acc_s3[k][AW-1:FB+WIDTH-1];
			if (&hi_d[k] || ~|hi_d[k]) begin
				sat_d[k] = acc_s3[k][FB+WIDTH-1:FB];
			end else begin
				sat_d[k] = acc_s3[k][AW-1] ? MINV : MAXV;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s4 <= sat_d;
		end
	end

	assign out_valid = v_s4;
	assign r         = r_s4;
endmodule

// File: rtl/core/quaternion_multiply_rotate.sv
// Quaternion multiply and vector rotate in signed fixed point (WIDTH bits,
// WIDTH/2 fraction bits, Q16.16 by default).
// The item channel carries a kind and two quaternions a and b. Kind multiply
// returns a*b; kind forward rotation returns a*(0,v)*conj(a) with v the vector
// part of b; kind reverse rotation returns conj(a)*((0,v)*a). The unused kind
// returns zero. Each product is rounded half up and saturated on its own.
// The result channel carries one transaction per item, in order.
// Each item passes through two product units of four register stages each
// (partial products, full products, signed sum, saturation) before its
// result is shown. One item is accepted every cycle while the receiver
// takes results.
// When the receiver stalls, the whole pipeline holds and ready falls; bubbles
// ahead of a stalled result do not close up, but nothing is lost or repeated.
// Reset clears the valid bits only; the block keeps no other state and needs
// no start-up pass.
module quaternion_multiply_rotate #(parameter int WIDTH = 32) (
	input logic       clk,
	input logic       arst_n,
	qmr_in_if.sink    item,
	qmr_out_if.source result
);
	import qmr_pkg::*;

	// The value one in the fixed-point format, used to pass a plain product
	// through the second unit unchanged.
	localparam logic signed [WIDTH-1:0] ONE =
		{{(WIDTH-WIDTH/2-1){1'b0}}, 1'b1, {(WIDTH/2){1'b0}}};

	logic                    en;
	logic signed [WIDTH-1:0] p1 [4];
	logic signed [WIDTH-1:0] q1 [4];
	logic signed [WIDTH-1:0] t1 [4];
	logic signed [WIDTH-1:0] p2 [4];
	logic signed [WIDTH-1:0] q2 [4];
	logic signed [WIDTH-1:0] r2 [4];
	logic                    pconj2, qconj2;
	logic                    v1, v2;

	// The kind and the rotation quaternion wait here while the first product
	// is formed, so that they line up with its result.
	kind_t                   kind_dly_q [QMUL_LAT];
	logic signed [WIDTH-1:0] a_dly_q [QMUL_LAT][4];

	// All stages move together whenever the output is free or being taken.
	assign en         = !v2 || result.ready;
	assign item.ready = en;

	// First product: a*b, a*(0,v) or (0,v)*a.
	always_comb begin
		case (item.kind)
			KIND_MUL: begin
				p1 = '{item.a_w, item.a_x, item.a_y, item.a_z};
				q1 = '{item.b_w, item.b_x, item.b_y, item.b_z};
			end
			KIND_ROT_FWD: begin
				p1 = '{item.a_w, item.a_x, item.a_y, item.a_z};
				q1 = '{'0, item.b_x, item.b_y, item.b_z};
			end
			KIND_ROT_REV: begin
				p1 = '{'0, item.b_x, item.b_y, item.b_z};
				q1 = '{item.a_w, item.a_x, item.a_y, item.a_z};
			end
			default: begin
				p1 = '{'0, '0, '0, '0};
				q1 = '{'0, '0, '0, '0};
			end
		endcase
	end

	qmr_qmul #(.WIDTH(WIDTH)) u_qmul1 (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (item.valid),
		.p         (p1),
		.q         (q1),
		.pconj     (1'b0),
		.qconj     (1'b0),
		.out_valid (v1),
		.r         (t1)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			kind_dly_q[0] <= item.kind;
			a_dly_q[0]    <= '{item.a_w, item.a_x, item.a_y, item.a_z};
			for (int i = 1; i < QMUL_LAT; i++) begin
				kind_dly_q[i] <= kind_dly_q[i-1];
				a_dly_q[i]    <= a_dly_q[i-1];
			end
		end
	end

	// Second product: t*conj(a), conj(a)*t, or t*1 for a plain product. The
	// unused kind already carries zero out of the first unit.
	always_comb begin
		pconj2 = 1'b0;
		qconj2 = 1'b0;
		case (kind_dly_q[QMUL_LAT-1])
			KIND_ROT_FWD: begin
				p2     = t1;
				q2     = a_dly_q[QMUL_LAT-1];
				qconj2 = 1'b1;
			end
			KIND_ROT_REV: begin
				p2     = a_dly_q[QMUL_LAT-1];
				q2     = t1;
				pconj2 = 1'b1;
			end
			default: begin
				p2 = t1;
				q2 = '{ONE, '0, '0, '0};
			end
		endcase
	end

	qmr_qmul #(.WIDTH(WIDTH)) u_qmul2 (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v1),
		.p         (p2),
		.q         (q2),
		.pconj     (pconj2),
		.qconj     (qconj2),
		.out_valid (v2),
		.r         (r2)
	);

	// The last stage of the second unit is the output register.
	assign result.valid = v2;
	assign result.r_w   = r2[0];
	assign result.r_x   = r2[1];
	assign result.r_y   = r2[2];
	assign result.r_z   = r2[3];
endmodule

// File: rtl/core/qmr_check.sv
module qmr_check #(parameter int WIDTH = 32) (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input logic [WIDTH-1:0] r_w,
	input logic [WIDTH-1:0] r_x,
	input logic [WIDTH-1:0] r_y,
	input logic [WIDTH-1:0] r_z
);
	// A result that is not taken stays and holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(r_w) && $stable(r_x) &&
			$stable(r_y) && $stable(r_z))
		else $error("result changed or vanished while stalled");

	// A receiver that takes results never holds back the item side.
	a_in_ready: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("item channel stalled while the result side was ready");

	// With the receiver ready throughout, an item shows its result once it has
	// passed through both product units.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) ##1 out_ready ##1 out_ready ##1 out_ready
			##1 out_ready ##1 out_ready ##1 out_ready ##1 out_ready |=> out_valid)
		else $error("result missing after the pipeline latency");

	// No result is offered while reset is held.
	a_reset: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result valid during reset");
endmodule

bind quaternion_multiply_rotate qmr_check #(.WIDTH(WIDTH)) u_qmr_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (item.valid),
	.in_ready  (item.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.r_w       (result.r_w),
	.r_x       (result.r_x),
	.r_y       (result.r_y),
	.r_z       (result.r_z)
);
